>>> sv/goodness_run_queue_scheduler_defines.svh
// Assertion macros used by the checker file.
`ifndef GOODNESS_RUN_QUEUE_SCHEDULER_DEFINES_SVH
`define GOODNESS_RUN_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while reset is asserted.
`define GRQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grq check failed");

// Next-cycle implication, sampled on clk, quiet while reset is asserted.
`define GRQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grq check failed");

`endif

>>> sv/grq_pkg.sv
`timescale 1ns / 1ps
package grq_pkg;

  // Operation codes carried in in_tuser.
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_WAKE     = 2'd1;
  localparam logic [1:0] OP_SLEEP    = 2'd2;
  localparam logic [1:0] OP_SCHEDULE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_QUEUED     = 2'd1;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd2;
  localparam logic [1:0] ST_IDLE_SLEEP = 2'd3;

  // Policy and run state codes.
  localparam logic [1:0] POL_NORMAL  = 2'd0;
  localparam logic [1:0] POL_RR      = 2'd2;
  localparam logic [1:0] RUN_RUNNING = 2'd0;
  localparam logic [1:0] RUN_INTR    = 2'd1;

  // Goodness constants.
  localparam logic signed [11:0] GOOD_FLOOR = -12'sd1000;
  localparam logic signed [11:0] GOOD_RT    = 12'sd1000;
  localparam logic [8:0]         WAKE_MARGIN = 9'd3;

  // One task table entry, with its run queue membership bit.
  typedef struct packed {
    logic        onq;
    logic [1:0]  policy;
    logic [7:0]  counter;
    logic [6:0]  prio;
    logic [6:0]  rt_prio;
    logic [1:0]  run;
    logic [31:0] sig;
    logic [31:0] blk;
  } task_rec_t;

  localparam int REC_W = $bits(task_rec_t);

endpackage

>>> sv/goodness_run_queue_scheduler.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_*      input      tuser: op; tdata: task fields (96 bits)
// out_*     output     tdata: status, chosen_task, best_goodness, resched, refilled
//
// After acceptance each operation reads its own and the current task's entries; write
// stores the fields, wake appends and sleep unlinks the task, schedule walks the queue
// and refills all counters on a zero best goodness. A new item waits for the last
// result. The one-read, one-write task and link memories serialize every step. After
// reset a clearing pass holds in_tready low. A stalled output holds the next item out.
module goodness_run_queue_scheduler #(
  parameter int TASKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  // [5:0] task_id, [7:6] sched_policy, [14:8] base_priority, [22:15] tick_counter,
  // [29:23] realtime_priority, [31:30] run_state, [63:32] pending_signals,
  // [95:64] blocked_signals
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [7:2] chosen_task, [19:8] best_goodness, [20] resched_flag,
  // [21] counters_refilled, [23:22] zero
  output logic [23:0] out_tdata
);

  localparam int IW = $clog2(TASKS);
  localparam int CW = IW + 1;
  localparam int LW = 2 * IW;

  // Slot map from the 6-bit task_id, folded into the table size.
  typedef logic [IW-1:0] idmap_t [64];
  function automatic idmap_t mk_idmap();
    idmap_t m;
    for (int i = 0; i < 64; i++) begin
      m[i] = IW'(i % TASKS);
    end
    return m;
  endfunction
  localparam idmap_t ID_MAP = mk_idmap();

  typedef enum logic [22:0] {
    S_CLR    = 23'h000001, S_IDLE  = 23'h000002, S_F1    = 23'h000004,
    S_F2     = 23'h000008, S_F3    = 23'h000010, S_U0    = 23'h000020,
    S_U1     = 23'h000040, S_U2    = 23'h000080, S_U3    = 23'h000100,
    S_U4     = 23'h000200, S_K0    = 23'h000400, S_K1    = 23'h000800,
    S_K2     = 23'h001000, S_K3    = 23'h002000, S_K4    = 23'h004000,
    S_K5     = 23'h008000, S_WSTART = 23'h010000, S_WFIRST = 23'h020000,
    S_WALK   = 23'h040000, S_WDONE = 23'h080000, S_REF   = 23'h100000,
    S_OUT    = 23'h200000, S_SPARE = 23'h400000
  } state_t;

  state_t state_r, state_nxt;

  // Captured item.
  logic [1:0]           op_r;
  logic [IW-1:0]        id_r;
  grq_pkg::task_rec_t   fld_r;
  grq_pkg::task_rec_t   tid_r;

  // Scheduler state and sequencing registers.
  logic [IW-1:0]        cur_r, cur_nxt;
  logic                 resched_r, resched_nxt;
  logic [IW-1:0]        qt_r, qt_nxt;
  logic                 requeue_r, requeue_nxt;
  logic [IW-1:0]        qn_r, qn_nxt, qp_r, qp_nxt;
  logic [IW-1:0]        p_r, p_nxt;
  logic [IW-1:0]        best_id_r, best_id_nxt;
  logic signed [11:0]   best_r, best_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 refilled_r, refilled_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Memory ports.
  logic                 t_we, l_we;
  logic [IW-1:0]        t_waddr, t_raddr, l_waddr, l_raddr;
  grq_pkg::task_rec_t   t_wdata, t_rdata;
  logic [LW-1:0]        l_wdata, l_rdata;

  grq_ram #(.WIDTH(grq_pkg::REC_W), .DEPTH(TASKS)) u_task_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  grq_ram #(.WIDTH(LW), .DEPTH(TASKS)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  logic [IW-1:0] l_next, l_prev;
  assign l_next = l_rdata[LW-1:IW];
  assign l_prev = l_rdata[IW-1:0];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);

  // Goodness of the entry being walked.
  logic signed [11:0] good;
  always_comb begin
    if (t_rdata.policy != grq_pkg::POL_NORMAL) begin
      good = grq_pkg::GOOD_RT + $signed({5'd0, t_rdata.rt_prio});
    end else begin
      good = $signed({4'd0, t_rdata.counter}) +
             $signed({11'd0, (t_rdata.counter != 8'd0) && (p_r == cur_r)});
    end
  end

  // Refill value of the entry last read from the task memory.
  logic [8:0] refill_sum;
  assign refill_sum = {2'd0, t_rdata.counter[7:1]} + {2'd0, t_rdata.prio};

  // Schedule decisions on the current task's entry.
  logic rr_exhaust, sig_wake, deq_cur;
  assign rr_exhaust = (t_rdata.counter == 8'd0) && (t_rdata.policy == grq_pkg::POL_RR);
  assign sig_wake   = (t_rdata.run == grq_pkg::RUN_INTR) &&
                      ((t_rdata.sig & ~t_rdata.blk) != 32'd0);
  assign deq_cur    = !sig_wake && (t_rdata.run != grq_pkg::RUN_RUNNING) &&
                      t_rdata.onq && (cur_r != '0);

  logic [CW-1:0] steps_inc;
  assign steps_inc = idx_r + CW'(1);

  // Sequencer.
  always_comb begin
    grq_pkg::task_rec_t pe;
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    resched_nxt   = resched_r;
    qt_nxt        = qt_r;
    requeue_nxt   = requeue_r;
    qn_nxt        = qn_r;
    qp_nxt        = qp_r;
    p_nxt         = p_r;
    best_id_nxt   = best_id_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    refilled_nxt  = refilled_r;
    out_valid_nxt = out_valid_r;
    t_we = 1'b0; t_waddr = id_r; t_wdata = fld_r; t_raddr = id_r;
    l_we = 1'b0; l_waddr = qt_r; l_wdata = '0;    l_raddr = qt_r;
    pe = t_rdata;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        t_we = 1'b1;
        t_waddr = idx_r[IW-1:0];
        t_wdata = '0;
        t_wdata.onq = (idx_r == '0);
        l_we = 1'b1;
        l_waddr = idx_r[IW-1:0];
        idx_nxt = steps_inc;
        if (steps_inc == CW'(TASKS)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          status_nxt   = grq_pkg::ST_OK;
          best_nxt     = '0;
          refilled_nxt = 1'b0;
          state_nxt    = S_F1;
        end
      end
      S_F1: begin
        t_raddr   = id_r;
        state_nxt = S_F2;
      end
      S_F2: begin
        t_raddr   = cur_r;
        state_nxt = S_F3;
      end
      S_F3: begin
        unique case (op_r)
          grq_pkg::OP_WRITE: begin
            t_we = 1'b1;
            t_wdata = fld_r;
            t_wdata.onq = tid_r.onq;
            state_nxt = S_OUT;
          end
          grq_pkg::OP_WAKE: begin
            pe = tid_r;
            pe.run = grq_pkg::RUN_RUNNING;
            qt_nxt = id_r;
            if (tid_r.onq) begin
              status_nxt = grq_pkg::ST_QUEUED;
              state_nxt = S_OUT;
            end else begin
              pe.onq = 1'b1;
              if (tid_r.policy != grq_pkg::POL_NORMAL ||
                  {1'b0, tid_r.counter} > {1'b0, t_rdata.counter} + grq_pkg::WAKE_MARGIN) begin
                resched_nxt = 1'b1;
              end
              state_nxt = S_K0;
            end
            t_we = 1'b1;
            t_wdata = pe;
          end
          grq_pkg::OP_SLEEP: begin
            qt_nxt = id_r;
            requeue_nxt = 1'b0;
            if (!tid_r.onq) begin
              status_nxt = grq_pkg::ST_NOT_QUEUED;
              state_nxt = S_OUT;
            end else if (id_r == '0) begin
              status_nxt = grq_pkg::ST_IDLE_SLEEP;
              state_nxt = S_OUT;
            end else begin
              pe = tid_r;
              pe.onq = 1'b0;
              t_we = 1'b1;
              t_wdata = pe;
              state_nxt = S_U0;
            end
          end
          default: begin
            // Schedule: fix up the current task before the walk.
            resched_nxt = 1'b0;
            if (rr_exhaust) begin
              pe.counter = {1'b0, t_rdata.prio};
            end
            if (sig_wake) begin
              pe.run = grq_pkg::RUN_RUNNING;
            end
            if (deq_cur) begin
              pe.onq = 1'b0;
            end
            t_we = 1'b1;
            t_waddr = cur_r;
            t_wdata = pe;
            qt_nxt = cur_r;
            requeue_nxt = rr_exhaust && (cur_r != '0) && t_rdata.onq && !deq_cur;
            if (deq_cur || requeue_nxt) begin
              state_nxt = S_U0;
            end else begin
              state_nxt = S_WSTART;
            end
          end
        endcase
      end
      // Unlink qt_r from the queue.
      S_U0: begin
        l_raddr = qt_r;
        state_nxt = S_U1;
      end
      S_U1: begin
        qn_nxt = l_next;
        qp_nxt = l_prev;
        l_raddr = l_next;
        state_nxt = S_U2;
      end
      S_U2: begin
        l_we = 1'b1;
        l_waddr = qn_r;
        l_wdata = {l_next, qp_r};
        state_nxt = S_U3;
      end
      S_U3: begin
        l_raddr = qp_r;
        state_nxt = S_U4;
      end
      S_U4: begin
        l_we = 1'b1;
        l_waddr = qp_r;
        l_wdata = {qn_r, l_prev};
        if (op_r == grq_pkg::OP_SLEEP) begin
          state_nxt = S_OUT;
        end else if (requeue_r) begin
          state_nxt = S_K0;
        end else begin
          state_nxt = S_WSTART;
        end
      end
      // Append qt_r at the queue tail.
      S_K0: begin
        l_raddr = '0;
        state_nxt = S_K1;
      end
      S_K1: begin
        qp_nxt = l_prev;
        l_we = 1'b1;
        l_waddr = qt_r;
        l_wdata = {IW'(0), l_prev};
        state_nxt = S_K2;
      end
      S_K2: begin
        l_raddr = qp_r;
        state_nxt = S_K3;
      end
      S_K3: begin
        l_we = 1'b1;
        l_waddr = qp_r;
        l_wdata = {qt_r, l_prev};
        state_nxt = S_K4;
      end
      S_K4: begin
        l_raddr = '0;
        state_nxt = S_K5;
      end
      S_K5: begin
        l_we = 1'b1;
        l_waddr = '0;
        l_wdata = {l_next, qt_r};
        state_nxt = (op_r == grq_pkg::OP_WAKE) ? S_OUT : S_WSTART;
      end
      // Queue walk for the strictly highest goodness.
      S_WSTART: begin
        l_raddr = '0;
        best_nxt = grq_pkg::GOOD_FLOOR;
        best_id_nxt = '0;
        idx_nxt = '0;
        state_nxt = S_WFIRST;
      end
      S_WFIRST: begin
        t_raddr = l_next;
        l_raddr = l_next;
        p_nxt = l_next;
        state_nxt = (l_next == '0) ? S_WDONE : S_WALK;
      end
      S_WALK: begin
        if (good > best_r) begin
          best_nxt = good;
          best_id_nxt = p_r;
        end
        idx_nxt = steps_inc;
        t_raddr = l_next;
        l_raddr = l_next;
        p_nxt = l_next;
        if (l_next == '0 || steps_inc == CW'(TASKS)) begin
          state_nxt = S_WDONE;
        end
      end
      S_WDONE: begin
        cur_nxt = best_id_r;
        idx_nxt = '0;
        if (best_r == 12'sd0) begin
          refilled_nxt = 1'b1;
          state_nxt = S_REF;
        end else begin
          state_nxt = S_OUT;
        end
      end
      // Counter refill sweep: read one slot while the previous one is written.
      S_REF: begin
        t_raddr = idx_r[IW-1:0];
        if (idx_r != '0) begin
          pe.counter = refill_sum[8] ? 8'hFF : refill_sum[7:0];
          t_we = 1'b1;
          t_waddr = IW'(idx_r - CW'(1));
          t_wdata = pe;
        end
        idx_nxt = steps_inc;
        if (idx_r == CW'(TASKS)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      cur_r       <= '0;
      resched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      resched_r   <= resched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    qt_r       <= qt_nxt;
    requeue_r  <= requeue_nxt;
    qn_r       <= qn_nxt;
    qp_r       <= qp_nxt;
    p_r        <= p_nxt;
    best_id_r  <= best_id_nxt;
    best_r     <= best_nxt;
    status_r   <= status_nxt;
    refilled_r <= refilled_nxt;
    if (state_r == S_F2) begin
      tid_r <= t_rdata;
    end
    if (in_tvalid && in_tready) begin
      op_r          <= in_tuser;
      id_r          <= ID_MAP[in_tdata[5:0]];
      fld_r.onq     <= 1'b0;
      fld_r.policy  <= in_tdata[7:6];
      fld_r.prio    <= in_tdata[14:8];
      fld_r.counter <= in_tdata[22:15];
      fld_r.rt_prio <= in_tdata[29:23];
      fld_r.run     <= in_tdata[31:30];
      fld_r.sig     <= in_tdata[63:32];
      fld_r.blk     <= in_tdata[95:64];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, refilled_r, resched_r, best_r, 6'(cur_r), status_r};

endmodule

>>> sv/grq_ram.sv
`timescale 1ns / 1ps
module grq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/grq_checker.sv
`timescale 1ns / 1ps
`include "goodness_run_queue_scheduler_defines.svh"
module grq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic [95:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result holds its value.
  `GRQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // One item is worked on at a time.
  `GRQ_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // A new item is taken only when the result slot is free or emptying.
  `GRQ_ASSERT_IMP(a_slot_free, in_tready, !out_tvalid || out_tready)

  // A refill only follows a schedule whose best goodness was zero.
  `GRQ_ASSERT_IMP(a_refill_zero, out_tvalid && out_tdata[21],
                  out_tdata[19:8] == 12'd0 && out_tdata[1:0] == grq_pkg::ST_OK)

endmodule

bind goodness_run_queue_scheduler grq_checker u_grq_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int NSLOT = 64;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  goodness_run_queue_scheduler #(.TASKS(NSLOT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [1:0]  op;
    logic [95:0] fields;
  } sched_cmd_t;

  // Shadow copy of the task table and run queue.
  logic [1:0]  sh_policy [NSLOT];
  logic [7:0]  sh_counter [NSLOT];
  logic [6:0]  sh_prio [NSLOT];
  logic [6:0]  sh_rt [NSLOT];
  logic [1:0]  sh_run [NSLOT];
  logic [31:0] sh_sig [NSLOT];
  logic [31:0] sh_blk [NSLOT];
  logic [5:0]  sh_next [NSLOT];
  logic [5:0]  sh_prev [NSLOT];
  logic        sh_onq [NSLOT];
  logic [5:0]  sh_cur;
  logic        sh_resched;
  logic [6:0]  sh_count;

  sched_cmd_t  pending_cmds[$];
  logic [23:0] expected_results[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;

  always #5 clk = ~clk;

  task automatic shadow_reset();
    for (int i = 0; i < NSLOT; i++) begin
      sh_policy[i] = '0; sh_counter[i] = '0; sh_prio[i] = '0; sh_rt[i] = '0;
      sh_run[i] = grq_pkg::RUN_RUNNING; sh_sig[i] = '0; sh_blk[i] = '0;
      sh_next[i] = '0; sh_prev[i] = '0; sh_onq[i] = 1'b0;
    end
    sh_onq[0] = 1'b1;
    sh_cur = '0;
    sh_resched = 1'b0;
    sh_count = '0;
  endtask

  task automatic append_tail(input logic [5:0] t);
    logic [5:0] last;
    last = sh_prev[0];
    sh_prev[t] = last;
    sh_next[last] = t;
    sh_next[t] = '0;
    sh_prev[0] = t;
  endtask

  task automatic unlink(input logic [5:0] t);
    sh_prev[sh_next[t]] = sh_prev[t];
    sh_next[sh_prev[t]] = sh_next[t];
  endtask

  task automatic dequeue(input logic [5:0] t, output logic [1:0] st);
    if (!sh_onq[t]) st = grq_pkg::ST_NOT_QUEUED;
    else if (t == 0) st = grq_pkg::ST_IDLE_SLEEP;
    else begin
      unlink(t);
      sh_onq[t] = 1'b0;
      sh_count = sh_count - 7'd1;
      st = grq_pkg::ST_OK;
    end
  endtask

  function automatic int task_goodness(input logic [5:0] t, input logic [5:0] prev);
    int w;
    if (sh_policy[t] != grq_pkg::POL_NORMAL) return 1000 + int'(sh_rt[t]);
    w = int'(sh_counter[t]);
    if (w != 0 && t == prev) w++;
    return w;
  endfunction

  // Applies one command to the shadow state and returns the packed result.
  task automatic run_scheduler_op(input sched_cmd_t c, output logic [23:0] res);
    logic [1:0] st;
    logic [1:0] dummy;
    logic [5:0] id;
    logic [5:0] prev;
    logic [5:0] pick;
    logic [5:0] p;
    logic [8:0] refill;
    int         best;
    int         w;
    bit         refilled;
    st = grq_pkg::ST_OK; best = 0; refilled = 0;
    id = c.fields[5:0];
    case (c.op)
      grq_pkg::OP_WRITE: begin
        sh_policy[id] = c.fields[7:6];
        sh_prio[id] = c.fields[14:8];
        sh_counter[id] = c.fields[22:15];
        sh_rt[id] = c.fields[29:23];
        sh_run[id] = c.fields[31:30];
        sh_sig[id] = c.fields[63:32];
        sh_blk[id] = c.fields[95:64];
      end
      grq_pkg::OP_WAKE: begin
        sh_run[id] = grq_pkg::RUN_RUNNING;
        if (sh_onq[id]) st = grq_pkg::ST_QUEUED;
        else begin
          if (sh_policy[id] != grq_pkg::POL_NORMAL ||
              {1'b0, sh_counter[id]} > {1'b0, sh_counter[sh_cur]} + grq_pkg::WAKE_MARGIN)
            sh_resched = 1'b1;
          sh_count = sh_count + 7'd1;
          append_tail(id);
          sh_onq[id] = 1'b1;
        end
      end
      grq_pkg::OP_SLEEP: dequeue(id, st);
      default: begin
        prev = sh_cur;
        pick = '0;
        sh_resched = 1'b0;
        if (sh_counter[prev] == 0 && sh_policy[prev] == grq_pkg::POL_RR) begin
          sh_counter[prev] = {1'b0, sh_prio[prev]};
          if (prev != 0 && sh_onq[prev]) begin
            unlink(prev);
            append_tail(prev);
          end
        end
        if (sh_run[prev] == grq_pkg::RUN_INTR && (sh_sig[prev] & ~sh_blk[prev]) != 0)
          sh_run[prev] = grq_pkg::RUN_RUNNING;
        else if (sh_run[prev] != grq_pkg::RUN_RUNNING)
          dequeue(prev, dummy);
        best = -1000;
        p = sh_next[0];
        for (int s = 0; p != 0 && s < NSLOT; s++) begin
          w = task_goodness(p, prev);
          if (w > best) begin
            best = w;
            pick = p;
          end
          p = sh_next[p];
        end
        if (best == 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            refill = {2'b0, sh_counter[i][7:1]} + {2'b0, sh_prio[i]};
            sh_counter[i] = (refill > 9'd255) ? 8'hFF : refill[7:0];
          end
          refilled = 1;
        end
        sh_cur = pick;
      end
    endcase
    res = {2'b00, refilled, sh_resched, best[11:0], sh_cur, st};
  endtask

  function automatic sched_cmd_t make_cmd(input logic [1:0] op, input logic [5:0] id,
                                         input logic [1:0] pol, input logic [6:0] pri,
                                         input logic [7:0] cnt, input logic [6:0] rt,
                                         input logic [1:0] run, input logic [31:0] sig,
                                         input logic [31:0] blk);
    sched_cmd_t c;
    c.op = op;
    c.fields = {blk, sig, run, rt, cnt, pri, pol, id};
    return c;
  endfunction

  function automatic sched_cmd_t random_write(input logic [5:0] id);
    logic [31:0] sig;
    logic [31:0] blk;
    sig = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
    blk = ($urandom_range(0, 2) == 0) ? ~sig : $urandom;
    return make_cmd(grq_pkg::OP_WRITE, id, 2'($urandom_range(0, 3)),
                    7'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom),
                    8'($urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom),
                    7'($urandom), 2'($urandom), sig, blk);
  endfunction

  // Driver: presents queued commands, idling at the current sender rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sched_cmd_t c;
        c = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= c.op;
        in_tdata <= c.fields;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict at acceptance so expectations line up with transaction order.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      logic [23:0] r;
      run_scheduler_op(sched_cmd_t'({in_tuser, in_tdata}), r);
      expected_results.push_back(r);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [23:0] e;
          e = expected_results.pop_front();
          if (e !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d task %0d/%0d good %0d/%0d rs %b/%b rf %b/%b",
                       e[1:0], out_tdata[1:0], e[7:2], out_tdata[7:2],
                       $signed(e[19:8]), $signed(out_tdata[19:8]),
                       e[20], out_tdata[20], e[21], out_tdata[21]);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Mostly well-formed sequences: write, wake, schedule, with sleeps and noise.
  task automatic queue_random(input int n);
    logic [5:0] id;
    int k;
    for (int i = 0; i < n; i++) begin
      id = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9));
      k = $urandom_range(0, 99);
      if (k < 25) pending_cmds.push_back(random_write(id));
      else if (k < 50)
        pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, id, 0, 0, 0, 0, 0, 0, 0));
      else if (k < 62)
        pending_cmds.push_back(make_cmd(grq_pkg::OP_SLEEP, id, 0, 0, 0, 0, 0, 0, 0));
      else if (k < 95)
        pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 6'($urandom),
                                        0, 0, 0, 0, 0, 0, 0));
      else
        pending_cmds.push_back(sched_cmd_t'({2'($urandom), $urandom, $urandom, $urandom}));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle sleep and wake, unqueued sleep, empty schedule, refill,
    // extremes of fields, realtime wake, round-robin exhaustion, signals.
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SLEEP, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SLEEP, 5, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 63, 3, 127, 255, 127, 3, '1, '1));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 1, grq_pkg::POL_NORMAL,
                                    127, 255, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 2, grq_pkg::POL_RR,
                                    9, 0, 50, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 2, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 3, grq_pkg::POL_NORMAL,
                                    4, 0, 0, grq_pkg::RUN_INTR, 1, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 3, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SLEEP, 2, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SLEEP, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 3, grq_pkg::POL_NORMAL,
                                    4, 0, 0, grq_pkg::RUN_INTR, 1, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WRITE, 3, grq_pkg::POL_NORMAL,
                                    4, 0, 0, 2, 1, 1));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_WAKE, 63, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(grq_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases with different idling mixes, including none.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 31) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 31) : 0;
      queue_random(400);
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/grq_pkg.sv
sv/grq_ram.sv
sv/goodness_run_queue_scheduler.sv
sv/grq_checker.sv
verif/testbench.sv
